>>> rtl/jes_pkg.sv
// shared types, marker codes and outcome codes of the exif segment scanner
package jes_pkg;

    localparam int BYTE_W = 8;
    localparam int OC_W   = 3;
    localparam int LEN_W  = 16;
    localparam int SIG_W  = 3;

    localparam logic [BYTE_W-1:0] MK_FILL   = 8'hFF;
    localparam logic [BYTE_W-1:0] MK_STUFF  = 8'h00;
    localparam logic [BYTE_W-1:0] MK_SOI    = 8'hD8;
    localparam logic [BYTE_W-1:0] MK_TEM    = 8'h01;
    localparam logic [BYTE_W-1:0] MK_RST_LO = 8'hD0;
    localparam logic [BYTE_W-1:0] MK_RST_HI = 8'hD7;
    localparam logic [BYTE_W-1:0] MK_EOI    = 8'hD9;
    localparam logic [BYTE_W-1:0] MK_SOS    = 8'hDA;
    localparam logic [BYTE_W-1:0] MK_APP1   = 8'hE1;

    localparam logic [LEN_W-1:0] LEN_EMPTY   = 16'd2;
    localparam logic [LEN_W-1:0] LEN_MIN_SIG = 16'd8;
    localparam logic [SIG_W-1:0] SIG_LEN     = 3'd6;

    localparam logic [OC_W-1:0] OC_CONT  = 3'd0;
    localparam logic [OC_W-1:0] OC_EXIF  = 3'd1;
    localparam logic [OC_W-1:0] OC_STOP  = 3'd2;
    localparam logic [OC_W-1:0] OC_FRAME = 3'd3;
    localparam logic [OC_W-1:0] OC_TRUNC = 3'd4;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic              end_of_run;
        logic [OC_W-1:0]   outcome;
        logic              has_byte;
        logic [BYTE_W-1:0] payload;
    } t_result;

    // "Exif\0\0"
    function automatic logic [BYTE_W-1:0] sig_byte(input logic [SIG_W-1:0] idx);
        logic [BYTE_W-1:0] v;
        unique case (idx)
            3'd0:    v = 8'h45;
            3'd1:    v = 8'h78;
            3'd2:    v = 8'h69;
            3'd3:    v = 8'h66;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/jes_in_reg.sv
// input register stage holding one accepted file byte
module jes_in_reg import jes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/jes_core.sv
// marker segment walker: scan state and per-byte step logic
module jes_core import jes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    typedef enum logic [2:0] {
        PH_SOI, PH_MARK, PH_CODE, PH_LENH, PH_LENL, PH_BODY, PH_DONE
    } t_phase;

    t_phase             r_phase,     n_phase;
    logic [1:0]         r_prefix,    n_prefix;
    logic [LEN_W-1:0]   r_remaining, n_remaining;
    logic [BYTE_W-1:0]  r_len_hi,    n_len_hi;
    logic               r_is_app1,   n_is_app1;
    logic [SIG_W-1:0]   r_sig_idx,   n_sig_idx;

    logic [BYTE_W-1:0]  b;
    logic               last;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   rem_dec;
    logic               put;
    logic               has;
    logic [BYTE_W-1:0]  pb;
    logic [OC_W-1:0]    oc;
    logic               sig_done;

    assign b       = i_item.data;
    assign last    = i_item.last;
    assign len     = {r_len_hi, b};
    assign rem_dec = r_remaining - LEN_W'(1);
    assign sig_done = (r_sig_idx >= SIG_LEN);

    always_comb begin
        n_phase     = r_phase;
        n_prefix    = r_prefix;
        n_remaining = r_remaining;
        n_len_hi    = r_len_hi;
        n_is_app1   = r_is_app1;
        n_sig_idx   = r_sig_idx;
        put = 1'b0;
        has = 1'b0;
        pb  = '0;
        oc  = OC_CONT;
        unique case (r_phase)
            PH_SOI: begin
                if (last) begin
                    put = 1'b1;
                    oc  = OC_TRUNC;
                end else begin
                    n_prefix = r_prefix + 2'd1;
                    if (r_prefix == 2'd1 || r_prefix == 2'd2) begin
                        n_phase = PH_MARK;
                    end
                end
            end
            PH_MARK: begin
                if (last) begin
                    put = 1'b1;
                    oc  = OC_TRUNC;
                end else if (b != MK_FILL) begin
                    put = 1'b1;
                    oc  = OC_FRAME;
                end else begin
                    n_phase = PH_CODE;
                end
            end
            PH_CODE: begin
                priority if (b == MK_FILL) begin
                    if (last) begin
                        put = 1'b1;
                        oc  = OC_TRUNC;
                    end
                end else if (b == MK_STUFF) begin
                    put = 1'b1;
                    oc  = OC_FRAME;
                end else if (b == MK_SOI || b == MK_TEM ||
                             (b >= MK_RST_LO && b <= MK_RST_HI)) begin
                    if (last) begin
                        put = 1'b1;
                        oc  = OC_TRUNC;
                    end else begin
                        n_phase = PH_MARK;
                    end
                end else if (b == MK_EOI || b == MK_SOS) begin
                    put = 1'b1;
                    oc  = OC_STOP;
                end else begin
                    n_is_app1 = (b == MK_APP1);
                    if (last) begin
                        put = 1'b1;
                        oc  = OC_TRUNC;
                    end else begin
                        n_phase = PH_LENH;
                    end
                end
            end
            PH_LENH: begin
                n_len_hi = b;
                if (last) begin
                    put = 1'b1;
                    oc  = OC_TRUNC;
                end else begin
                    n_phase = PH_LENL;
                end
            end
            PH_LENL: begin
                priority if (len < LEN_EMPTY) begin
                    put = 1'b1;
                    oc  = OC_FRAME;
                end else if (last) begin
                    put = 1'b1;
                    oc  = OC_TRUNC;
                end else if (len == LEN_EMPTY) begin
                    n_phase = PH_MARK;
                end else begin
                    n_remaining = len - LEN_EMPTY;
                    if (len < LEN_MIN_SIG) begin
                        n_is_app1 = 1'b0;
                    end
                    n_sig_idx = '0;
                    n_phase   = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_remaining == '0) begin
                    n_phase = PH_MARK;
                    if (last) begin
                        put = 1'b1;
                        oc  = OC_TRUNC;
                    end
                end else begin
                    n_remaining = rem_dec;
                    if (r_is_app1 && sig_done) begin
                        put = 1'b1;
                        has = 1'b1;
                        pb  = b;
                        if (rem_dec == '0) begin
                            oc = OC_EXIF;
                        end else if (last) begin
                            oc = OC_TRUNC;
                        end
                    end else begin
                        if (r_is_app1) begin
                            if (b == sig_byte(r_sig_idx)) begin
                                n_sig_idx = r_sig_idx + SIG_W'(1);
                                if (r_sig_idx == SIG_LEN - SIG_W'(1) && rem_dec == '0) begin
                                    put = 1'b1;
                                    oc  = OC_EXIF;
                                end
                            end else begin
                                n_is_app1 = 1'b0;
                            end
                        end
                        if (!put) begin
                            if (last) begin
                                put = 1'b1;
                                oc  = OC_TRUNC;
                            end else if (rem_dec == '0) begin
                                n_phase = PH_MARK;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (put && oc != OC_CONT) begin
            n_phase = PH_DONE;
        end
        if (last) begin
            n_phase     = PH_SOI;
            n_prefix    = '0;
            n_remaining = '0;
            n_len_hi    = '0;
            n_is_app1   = 1'b0;
            n_sig_idx   = '0;
        end
    end

    assign o_res_valid      = i_fire && put;
    assign o_res.payload    = pb;
    assign o_res.has_byte   = has;
    assign o_res.outcome    = oc;
    assign o_res.end_of_run = (oc != OC_CONT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOI;
            r_prefix    <= '0;
            r_remaining <= '0;
            r_len_hi    <= '0;
            r_is_app1   <= 1'b0;
            r_sig_idx   <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_prefix    <= n_prefix;
            r_remaining <= n_remaining;
            r_len_hi    <= n_len_hi;
            r_is_app1   <= n_is_app1;
            r_sig_idx   <= n_sig_idx;
        end
    end

    a_payload_after_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.has_byte |-> r_phase == PH_BODY && r_is_app1 && sig_done)
        else $error("payload byte outside a matched exif segment");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && last |=> r_phase == PH_SOI && r_prefix == '0 && !r_is_app1)
        else $error("scan state not cleared after last byte of file");

    a_terminal_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.end_of_run && !last |=> r_phase == PH_DONE)
        else $error("terminal outcome did not stop the scan");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == PH_DONE |-> !o_res_valid)
        else $error("result produced after terminal outcome");

endmodule

>>> rtl/jes_out_reg.sv
// result register driving the output stream
module jes_out_reg import jes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/jpeg_exif_segment_scanner_top.sv
// top level of the jpeg exif segment scanner
//
// Input stream: one file byte per transaction on s_axis_tdata, s_axis_tlast
// set on the final byte of the file. The block skips the start-of-image
// marker, walks the marker segments and passes out the body of the first
// APP1 segment that opens with the Exif signature, starting at the TIFF header.
// Output stream: zero or one result per input byte. m_axis_tdata carries the
// payload byte, m_axis_tuser flags whether it is valid and gives the outcome
// (continuing, exif complete, SOS/EOI, framing error, file ended or truncated),
// m_axis_tlast marks the terminal result of a file. After a terminal result
// further bytes give nothing until the last byte of the file, which returns
// the scanner to its start state for the next file.
// Throughput is one byte per cycle while the output does not stall: an input
// register and a result register bracket the combinational marker decode and
// state update, and each result reaches the output through both registers.
// Reset (synchronous, active low) empties both registers and restarts the scan.
// When a result waits on a low m_axis_tready it holds and no byte advances;
// once the input register is full, s_axis_tready stays low until it drains.
module jpeg_exif_segment_scanner_top import jes_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] file_byte
    input  logic              s_axis_tlast,   // last_of_file
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [OC_W:0]     m_axis_tuser,   // [0] has_byte, [3:1] outcome
    output logic              m_axis_tlast    // end_of_run
);

    t_item   in_item;
    t_item   cur_item;
    logic    cur_valid;
    logic    advance;
    logic    out_space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.data = s_axis_tdata;
    assign in_item.last = s_axis_tlast;
    assign advance      = cur_valid && out_space;

    jes_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (cur_valid),
        .o_item  (cur_item),
        .i_take  (advance)
    );

    jes_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (cur_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jes_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_space (out_space),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = out_res.payload;
    assign m_axis_tuser = {out_res.outcome, out_res.has_byte};
    assign m_axis_tlast = out_res.end_of_run;

endmodule
